/* design/rtel_pkg.sv */
// Shared types and constants for the range table lookup block.
// Used by rtel_ctrl, rtel_dp and range_table_eytzinger_lookup.
// No dependencies.
package rtel_pkg;

	// Field widths of the item, result and cfg ports
	localparam int SLOT_W  = 10;
	localparam int WORD_W  = 32;
	localparam int CP_W    = 21;
	localparam int CAT_W   = 3;
	localparam int COUNT_W = 11;

	// Walk index: limit is at most 2047, so 2*idx+1 stays below 4096
	localparam int IDX_W = 12;
	// Holds any depth in the parameter range (up to 65536)
	localparam int LIM_W = 17;

	// Range word layout
	localparam int START_LSB  = 0;
	localparam int LEN_LSB    = 21;
	localparam int LEN_N_W    = 8;
	localparam int LEN_W_W    = 9;
	localparam int CAT_LSB    = 29;
	localparam int HI_W       = CP_W + 1;

	localparam logic [CAT_W-1:0] CAT_WIDE_LEN = 3'd5;
	localparam logic [CAT_W-1:0] CAT_NONE     = 3'd0;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} rtel_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} rtel_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_cfg;
		logic write_slot;
		logic start;
		logic step;
	} rtel_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic done;
	} rtel_sts_t;

endpackage

/* design/rtel_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/rtel_ctrl.sv */
// Controller for the range table lookup: handshakes and walk sequencing.
// Depends on rtel_pkg.
module rtel_ctrl
	import rtel_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      opcode,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	output rtel_cmd_t cmd,
	input  rtel_sts_t sts
);

	rtel_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;
	logic        is_lookup;
	logic        finish;

	// Take an item only in idle and when the result slot is free or freeing
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign is_lookup = (opcode == OP_LOOKUP);
	assign cfg_ready = (state_q == ST_IDLE);

	// Commands
	always_comb begin
		cmd            = '0;
		cmd.load_cfg   = cfg_valid && cfg_ready;
		cmd.write_slot = accept && !is_lookup;
		cmd.start      = accept && is_lookup;
		cmd.step       = (state_q == ST_WALK);
	end

	// Result ready: empty tree at start, or walk ends
	assign finish = (cmd.start && sts.empty) || (cmd.step && sts.done);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start && !sts.empty) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set on finish, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/rtel_dp.sv */
// Datapath for the range table lookup: table RAM, walk index, compare, result.
// Depends on rtel_pkg and rtel_ram.
module rtel_dp
	import rtel_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rtel_cmd_t          cmd,
	output rtel_sts_t          sts,
	input  logic [COUNT_W-1:0] cfg_data,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [WORD_W-1:0]  word,
	input  logic [CP_W-1:0]    code_point,
	output logic               found,
	output logic [CAT_W-1:0]   category
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

	logic [COUNT_W-1:0] table_count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CP_W-1:0]    cp_q;
	logic               found_q;
	logic [CAT_W-1:0]   category_q;

	logic [LIM_W-1:0]   count_l;
	logic [LIM_W-1:0]   limit;
	logic               we;
	logic               re;
	logic [AW-1:0]      raddr;
	logic [WORD_W-1:0]  rdata;

	logic [CP_W-1:0]    lo;
	logic [CAT_W-1:0]   cat;
	logic [LEN_W_W-1:0] len;
	logic [HI_W-1:0]    hi;
	logic               below;
	logic               hit;
	logic [IDX_W-1:0]   next_idx;
	logic               next_end;

	// Table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= COUNT_W'(1);
		end else if (cmd.load_cfg) begin
			table_count_q <= cfg_data;
		end
	end

	// Effective limit: count clipped to the table depth
	assign count_l = LIM_W'(table_count_q);
	assign limit   = (count_l > DEPTH_L) ? DEPTH_L : count_l;

	// Decode the word read for the current node
	assign lo    = rdata[START_LSB +: CP_W];
	assign cat   = rdata[CAT_LSB +: CAT_W];
	assign len   = (cat == CAT_WIDE_LEN) ? rdata[LEN_LSB +: LEN_W_W]
	                                     : LEN_W_W'(rdata[LEN_LSB +: LEN_N_W]);
	assign hi    = HI_W'(lo) + HI_W'(len);
	assign below = (cp_q < lo);
	assign hit   = !below && (HI_W'(cp_q) <= hi);

	// Child index: left when below the range, right when above it
	assign next_idx = {idx_q[IDX_W-2:0], !below};
	assign next_end = (LIM_W'(next_idx) >= limit);

	assign sts.empty = (limit <= LIM_W'(1));
	assign sts.done  = hit || next_end;

	// Table RAM ports: the next node is read while the current one is compared
	assign we    = cmd.write_slot && (LIM_W'(slot) < DEPTH_L);
	assign re    = cmd.start || cmd.step;
	assign raddr = cmd.start ? AW'(ROOT) : AW'(next_idx);

	rtel_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(slot)),
		.wdata(word),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Walk state
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q <= ROOT;
			cp_q  <= code_point;
		end else if (cmd.step) begin
			idx_q <= next_idx;
		end
	end

	// Result register, written only when a lookup finishes
	always_ff @(posedge clk) begin
		if (cmd.start && sts.empty) begin
			found_q    <= 1'b0;
			category_q <= CAT_NONE;
		end else if (cmd.step && sts.done) begin
			found_q    <= hit;
			category_q <= hit ? cat : CAT_NONE;
		end
	end

	assign found    = found_q;
	assign category = category_q;

endmodule

/* design/range_table_eytzinger_lookup.sv */
// Top level of the range table lookup block.
// Depends on rtel_pkg, rtel_ctrl, rtel_dp (and rtel_ram through rtel_dp).

// Range table lookup over a binary search tree kept in Eytzinger order
// (slot 1 is the root, children of slot i are 2i and 2i+1). An item with
// opcode 0 stores a 32-bit range word and returns nothing. An item with
// opcode 1 walks the tree with a code point and returns found and category.
// The walk reads one tree level per clock from the table RAM's single
// registered read port, so a lookup holds the block until it has visited at
// most ceil(log2(limit)) levels, where limit is table_count clipped to
// TABLE_DEPTH. Items are taken one at a time; a result waits in an output
// register, and a new item is taken while it waits unless the result itself
// is stalled. table_count is written through the cfg port while no lookup is
// in flight (cfg_ready is high then). Table slots must be written before a
// lookup can reach them; there is no clearing pass after reset.
module range_table_eytzinger_lookup
	import rtel_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [WORD_W-1:0]  word,
	input  logic [CP_W-1:0]    code_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [CAT_W-1:0]   category,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	rtel_cmd_t cmd;
	rtel_sts_t sts;

	rtel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rtel_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_data  (cfg_data),
		.slot      (slot),
		.word      (word),
		.code_point(code_point),
		.found     (found),
		.category  (category)
	);

	// A miss always reports the null class
	a_miss_cat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (category == CAT_NONE))
		else $error("miss with nonzero category");

	// After a lookup is taken the block is either walking or showing a result
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode == OP_LOOKUP)) |=> (in_stall || out_valid))
		else $error("lookup lost after accept");

	// A result only follows a lookup accept or a walk in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			($past(in_stall) || $past(in_valid && (opcode == OP_LOOKUP))))
		else $error("result without lookup");

	// A write item never produces a result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode == OP_WRITE) && !out_valid) |=> !out_valid)
		else $error("result after write");

endmodule

/* bench/tb_range_table_eytzinger_lookup.sv */
// Testbench for range_table_eytzinger_lookup: builds sorted range trees, walks them
// with code points and checks found/category against an in-bench tree walk.
// Depends on rtel_pkg and range_table_eytzinger_lookup.
`timescale 1ns / 1ps

module tb_range_table_eytzinger_lookup;
	import rtel_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int CP_MAX      = 1114111;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic             found;
		logic [CAT_W-1:0] category;
	} lookup_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = OP_WRITE;
	logic [SLOT_W-1:0]  slot = '0;
	logic [WORD_W-1:0]  word = '0;
	logic [CP_W-1:0]    code_point = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic [CAT_W-1:0]   category;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	// Shadow of the block's state
	logic [WORD_W-1:0]  range_words [TABLE_DEPTH];
	logic [COUNT_W-1:0] table_count_q = 11'd1;
	lookup_result_t     pending_results [$];
	lookup_result_t     oldest_result;

	int   error_count = 0;
	int   cycle_count = 0;
	int   burst_left = 0;
	bit   pacing_on = 1'b1;
	bit   hold_request = 1'b0;

	range_table_eytzinger_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.slot      (slot),
		.word      (word),
		.code_point(code_point),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.category  (category),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		error_count++;
		if (error_count <= 100) begin
			$display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	// Unpack a range word; class 5 borrows bit 29 as the ninth length bit
	function automatic void decode_range(input logic [WORD_W-1:0] w, output int lo,
			output int hi, output logic [CAT_W-1:0] cat);
		int len;
		cat = w[31:29];
		lo = int'(w[20:0]);
		len = (cat == CAT_WIDE_LEN) ? int'(w[29:21]) : int'(w[28:21]);
		hi = lo + len;
	endfunction

	// Walk the shadow tree from the root, as the block does
	function automatic lookup_result_t classify_code_point(input int cp);
		lookup_result_t r;
		int lim, idx, lo, hi;
		logic [CAT_W-1:0] cat;
		r.found = 1'b0;
		r.category = CAT_NONE;
		lim = int'(table_count_q);
		if (lim > TABLE_DEPTH) begin
			lim = TABLE_DEPTH;
		end
		idx = 1;
		while (idx < lim && !r.found) begin
			decode_range(range_words[idx], lo, hi, cat);
			if (cp < lo) begin
				idx = 2 * idx;
			end else if (cp <= hi) begin
				r.found = 1'b1;
				r.category = cat;
			end else begin
				idx = 2 * idx + 1;
			end
		end
		return r;
	endfunction

	// Offer one item, with burst/gap pacing; update the shadow when it is taken
	task automatic send_item(input rtel_op_t op, input logic [SLOT_W-1:0] s,
			input logic [WORD_W-1:0] w, input logic [CP_W-1:0] cp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(32, 1);
			gap = pacing_on ? $urandom_range(8, 0) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		slot <= s;
		word <= w;
		code_point <= cp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == OP_WRITE) begin
			range_words[s] = w;
		end else begin
			pending_results.push_back(classify_code_point(int'(cp)));
		end
	endtask

	task automatic send_write(input int s, input logic [WORD_W-1:0] w);
		send_item(OP_WRITE, SLOT_W'(s), w, CP_W'($urandom));
	endtask

	task automatic send_lookup(input int cp);
		send_item(OP_LOOKUP, SLOT_W'($urandom), WORD_W'($urandom), CP_W'(cp));
	endtask

	// Sender goes quiet until every lookup has answered, then lets the block settle
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic set_table_count(input logic [COUNT_W-1:0] count);
		wait_for_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		table_count_q = count;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sorted disjoint ranges laid out in Eytzinger order over slots 1..n
	task automatic build_sorted_tree(input int n);
		logic [WORD_W-1:0] words [TABLE_DEPTH];
		logic [CAT_W-1:0]  cat;
		logic [7:0]        len_bits;
		int idx, cursor, start_pt, len;
		cursor = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(1000, 1);
		idx = 1;
		while (2 * idx <= n) idx = 2 * idx;
		while (idx != 0) begin
			cat = CAT_W'($urandom);
			len_bits = $urandom_range(3, 0) == 0 ? 8'd0 : 8'($urandom);
			start_pt = cursor + ($urandom_range(3, 0) == 0 ? 0 : $urandom_range(800, 1));
			len = (cat == CAT_WIDE_LEN) ? 256 + int'(len_bits) : int'(len_bits);
			words[idx] = {cat, len_bits, start_pt[20:0]};
			cursor = start_pt + len + 1;
			// next slot in order: leftmost of the right subtree, else climb
			if (2 * idx + 1 <= n) begin
				idx = 2 * idx + 1;
				while (2 * idx <= n) idx = 2 * idx;
			end else begin
				while (idx[0]) idx = idx >> 1;
				idx = idx >> 1;
			end
		end
		for (int i = 1; i <= n; i++) begin
			send_write(i, words[i]);
		end
	endtask

	// Lookups aimed at ranges and their edges, mixed with stray writes
	task automatic run_traffic(input int items, input int write_pct);
		int n, s, lo, hi, pick;
		logic [CAT_W-1:0] cat;
		n = int'(table_count_q);
		if (n > TABLE_DEPTH) begin
			n = TABLE_DEPTH;
		end
		n = n - 1;
		for (int i = 0; i < items; i++) begin
			if (n < 1 || $urandom_range(99, 0) < write_pct) begin
				send_write($urandom_range(TABLE_DEPTH - 1, 0), WORD_W'($urandom));
			end else begin
				s = $urandom_range(n, 1);
				decode_range(range_words[s], lo, hi, cat);
				case ($urandom_range(7, 0))
					0, 1, 2: pick = lo + $urandom_range(hi - lo, 0);
					3: pick = lo;
					4: pick = hi;
					5: pick = lo - 1;
					6: pick = hi + 1;
					default: pick = $urandom_range(CP_MAX, 0);
				endcase
				if (pick < 0 || pick > CP_MAX) begin
					pick = $urandom_range(CP_MAX, 0);
				end
				send_lookup(pick);
			end
		end
	endtask

	// Count of one after reset, then zero: the tree is empty, nothing is found
	task automatic test_empty_tree();
		send_lookup(0);
		send_lookup(CP_MAX);
		set_table_count(11'd0);
		send_lookup(12345);
		send_write(5, 32'h0);
		send_lookup(0);
	endtask

	// Extreme words and slots, a wide class-5 range and both tree directions
	task automatic test_edge_words();
		send_write(0, 32'hFFFF_FFFF);
		send_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF);
		send_write(1, {CAT_WIDE_LEN, 8'h00, 21'd100});     // 100..356
		send_write(2, {3'd7, 8'h00, 21'd0});               // 0..0
		send_write(3, {3'd2, 8'hFF, 21'h1F_FFFF});         // top of the start field
		set_table_count(11'd4);
		send_lookup(0);
		send_lookup(100);
		send_lookup(356);
		send_lookup(357);
		send_lookup(50);
		send_lookup(CP_MAX);
	endtask

	task automatic test_small_tree();
		set_table_count(11'd8);
		build_sorted_tree(7);
		run_traffic(150, 10);
	endtask

	task automatic test_full_tree();
		set_table_count(11'd1024);
		build_sorted_tree(TABLE_DEPTH - 1);
		run_traffic(250, 8);
	endtask

	// Partial last level and very shallow walks over the same table
	task automatic test_partial_counts();
		set_table_count(11'd1000);
		pacing_on = 1'b0;
		run_traffic(50, 5);
		pacing_on = 1'b1;
		set_table_count(11'd2);
		run_traffic(50, 10);
		set_table_count(11'd3);
		run_traffic(50, 10);
	endtask

	// Counts above the table depth walk as if the count were the depth
	task automatic test_count_beyond_table();
		set_table_count(11'd2047);
		run_traffic(60, 10);
		set_table_count(11'd1025);
		run_traffic(60, 10);
	endtask

	// Output held off long enough that the block backs up into its input
	task automatic test_output_hold();
		set_table_count(11'd1024);
		pacing_on = 1'b0;
		hold_request = 1'b1;
		run_traffic(60, 0);
		wait_for_results();
		pacing_on = 1'b1;
	endtask

	// Receiver stall pattern: runs of random length and density, plus long holds
	initial begin : out_stall_pattern
		int run_left, stall_pct, hold_left;
		run_left = 0;
		stall_pct = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (run_left == 0) begin
				run_left = $urandom_range(40, 1);
				case ($urandom_range(3, 0))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			run_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99, 0) < stall_pct);
			end
		end
	end

	// Result checker: each accepted result against the oldest pending lookup
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 1);
			end else begin
				oldest_result = pending_results.pop_front();
				if (found !== oldest_result.found) begin
					report_mismatch("found", oldest_result.found, found);
				end
				if (category !== oldest_result.category) begin
					report_mismatch("category", oldest_result.category, category);
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_tree();
		test_edge_words();
		test_small_tree();
		test_full_tree();
		test_partial_counts();
		test_count_beyond_table();
		test_output_hold();
		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
